### design/dwtp_pkg.sv
// ----------------------------------------------------------------------------
// dwtp_pkg
// Shared types and codes of the deadline-weighted task picker.
// ----------------------------------------------------------------------------
`default_nettype none

package dwtp_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int unsigned ELAPSED_W = 24;
    localparam int unsigned PEN_W     = 27;   // 2*(deadline*256 - duration - elapsed)
    localparam int unsigned SCORE_W   = 43;   // penalty * importance

    // One word of the task memory
    typedef struct packed {
        logic               valid;
        logic [7:0]         arrival;
        logic [15:0]        duration;
        logic signed [15:0] importance;
    } entry_t;

    // Tag that follows a read through the scan pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } scan_tag_t;

endpackage

`default_nettype wire

### design/dwtp_table.sv
// ----------------------------------------------------------------------------
// dwtp_table
// Task memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtp_table
    import dwtp_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned IDX_W       = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire scan_tag_t        rd_tag,
    input  wire logic [IDX_W-1:0] rd_addr,
    output scan_tag_t             rd_tag_q,
    output logic [IDX_W-1:0]      rd_addr_q,
    output entry_t                rd_data_q
);

    entry_t    mem [TABLE_DEPTH];
    scan_tag_t tag_reg;
    logic [IDX_W-1:0] addr_reg;
    entry_t    data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_tag.vld)
        begin
            data_reg <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= rd_tag;
        end
    end

    assign rd_tag_q  = tag_reg;
    assign rd_addr_q = addr_reg;
    assign rd_data_q = data_reg;

endmodule

`default_nettype wire

### design/dwtp_scorer.sv
// ----------------------------------------------------------------------------
// dwtp_scorer
// Scores each scanned entry and keeps the running best (lowest index on tie).
// ----------------------------------------------------------------------------
`default_nettype none

module dwtp_scorer
    import dwtp_pkg::*;
#(
    parameter int unsigned IDX_W = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [25:0]    base,       // deadline*256 - elapsed
    input  wire logic [ELAPSED_W-1:0]  elapsed,
    input  wire scan_tag_t             in_tag,
    input  wire logic [IDX_W-1:0]      in_idx,
    input  wire entry_t                in_entry,
    output logic                       done,
    output logic                       have,
    output logic [IDX_W-1:0]           best_idx,
    output logic [15:0]                best_duration
);

    logic signed [25:0]        pen;
    logic signed [PEN_W-1:0]   pen2;
    logic signed [SCORE_W-1:0] score;
    logic                      ready;

    scan_tag_t                 s1_tag_reg;
    logic                      s1_ready_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic [15:0]               s1_dur_reg;
    logic signed [SCORE_W-1:0] s1_score_reg;

    logic                      have_reg;
    logic                      done_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [15:0]               best_dur_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic                      take;

    assign pen   = base - $signed({10'd0, in_entry.duration});
    assign pen2  = {pen, 1'b0};
    assign score = SCORE_W'(pen2) * SCORE_W'(in_entry.importance);
    assign ready = in_entry.valid
                   && ({8'd0, in_entry.arrival, 8'd0} <= elapsed);

    always_ff @(posedge clk)
    begin
        s1_ready_reg <= ready;
        s1_idx_reg   <= in_idx;
        s1_dur_reg   <= in_entry.duration;
        s1_score_reg <= score;
    end

    // strict greater keeps the earlier (lower) index on a tie
    assign take = s1_tag_reg.vld && s1_ready_reg
                  && (!have_reg || (s1_score_reg > best_score_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg   <= s1_idx_reg;
            best_dur_reg   <= s1_dur_reg;
            best_score_reg <= s1_score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            have_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_tag_reg <= in_tag;
            done_reg   <= s1_tag_reg.vld && s1_tag_reg.last;
            if (start)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    assign done          = done_reg;
    assign have          = have_reg;
    assign best_idx      = best_idx_reg;
    assign best_duration = best_dur_reg;

endmodule

`default_nettype wire

### design/deadline_weighted_task_picker.sv
// ----------------------------------------------------------------------------
// deadline_weighted_task_picker
// Task table with deadline-weighted selection of the next ready task.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   tuser: operation; tdata: entry_index, arrival_hour,
//                task_duration, task_importance
//  m_*      out  tuser: found; tdata: chosen_index, chosen_duration,
//                elapsed_after
//  cfg      in   deadline_hours_wr_en / deadline_hours_wr_data
//
//  Load: one table write for an index inside the table. Select: one memory
//  read per entry through the single read port, two stages for score and
//  compare, then write-back; s_tready stays low until the select is done.
//  Clear: one memory word per cycle, s_tready low throughout.
//  After reset the same clearing pass runs (s_tready low).
//  A result waiting in the output register only stalls a select at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_weighted_task_picker
    import dwtp_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        deadline_hours_wr_en,
    input  wire logic [15:0] deadline_hours_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // entry_index, arrival_hour, task_duration,
                                       // task_importance, zero pad
    input  wire logic [1:0]  s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // chosen_index, chosen_duration,
                                       // elapsed_after, zero pad
    output logic [0:0]       m_tuser   // found
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [15:0]            deadline_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic signed [25:0]     base_reg, base_next;
    logic                   out_vld_reg, out_vld_next;
    logic                   out_found_reg, out_found_next;
    logic [5:0]             out_idx_reg, out_idx_next;
    logic [15:0]            out_dur_reg, out_dur_next;
    logic [ELAPSED_W-1:0]   out_elap_reg, out_elap_next;

    logic [1:0]             in_op;
    logic [5:0]             in_index;
    entry_t                 in_entry;
    logic                   in_fire;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_data;
    scan_tag_t              rd_tag;
    scan_tag_t              rd_tag_q;
    logic [IDX_W-1:0]       rd_addr_q;
    entry_t                 rd_data_q;

    logic                   start;
    logic                   sc_done;
    logic                   sc_have;
    logic [IDX_W-1:0]       sc_idx;
    logic [15:0]            sc_dur;
    logic [ELAPSED_W:0]     elap_sum;

    assign in_op               = s_tuser;
    assign in_index            = s_tdata[5:0];
    assign in_entry.valid      = 1'b1;
    assign in_entry.arrival    = s_tdata[13:6];
    assign in_entry.duration   = s_tdata[29:14];
    assign in_entry.importance = s_tdata[45:30];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign elap_sum = {1'b0, elapsed_reg} + {9'd0, sc_dur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
        end
        else if (deadline_hours_wr_en)
        begin
            deadline_reg <= deadline_hours_wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        elapsed_next   = elapsed_reg;
        base_next      = base_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_dur_next   = out_dur_reg;
        out_elap_next  = out_elap_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        rd_tag         = '0;
        start          = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                // invalidate one word per cycle
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (32'(in_index) < TABLE_DEPTH)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = IDX_W'(in_index);
                                wr_data = in_entry;
                            end
                        end
                        OP_SELECT:
                        begin
                            start      = 1'b1;
                            cnt_next   = '0;
                            base_next  = $signed({2'd0, deadline_reg, 8'd0})
                                         - $signed({2'd0, elapsed_reg});
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            elapsed_next = '0;
                            cnt_next     = '0;
                            state_next   = ST_CLR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_tag.vld  = 1'b1;
                rd_tag.last = (cnt_reg == LAST_IDX);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sc_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_found_next = sc_have;
                    out_idx_next   = '0;
                    out_dur_next   = '0;
                    out_elap_next  = elapsed_reg;
                    if (sc_have)
                    begin
                        // retire the winner: clear its valid bit, advance time
                        wr_en          = 1'b1;
                        wr_addr        = sc_idx;
                        out_idx_next   = 6'(sc_idx);
                        out_dur_next   = sc_dur;
                        elapsed_next   = elap_sum[ELAPSED_W] ? '1
                                         : elap_sum[ELAPSED_W-1:0];
                        out_elap_next  = elapsed_next;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_dur_reg   <= out_dur_next;
        out_elap_reg  <= out_elap_next;
    end

    dwtp_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_tag    (rd_tag),
        .rd_addr   (cnt_reg),
        .rd_tag_q  (rd_tag_q),
        .rd_addr_q (rd_addr_q),
        .rd_data_q (rd_data_q)
    );

    dwtp_scorer #(
        .IDX_W (IDX_W)
    ) u_scorer (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .base          (base_reg),
        .elapsed       (elapsed_reg),
        .in_tag        (rd_tag_q),
        .in_idx        (rd_addr_q),
        .in_entry      (rd_data_q),
        .done          (sc_done),
        .have          (sc_have),
        .best_idx      (sc_idx),
        .best_duration (sc_dur)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {2'b00, out_elap_reg, out_dur_reg, out_idx_reg};

    // no table write may disturb a scan in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_WAIT) |-> !wr_en)
        else $error("table written during scan");

    // the scorer only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sc_done |-> (state_reg == ST_WAIT))
        else $error("scorer done outside wait");

    // a found task has already been added to the elapsed time
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ({8'd0, m_tdata[21:6]} <= m_tdata[45:22]))
        else $error("elapsed_after below chosen duration");

    // not found reports zero slot and zero duration
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[21:0] == 22'd0))
        else $error("not-found beat carries task data");

endmodule

`default_nettype wire

### bench/tb_deadline_weighted_task_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_weighted_task_picker
// Self-checking bench for the deadline-weighted task picker. Loads, selects,
// clears and unused codes go in on the input stream. A bench-side copy of
// the task table predicts each select result: which ready entry wins, its
// duration and the new elapsed time. Results are checked in order against
// those predictions. Both stream sides idle at random, and one test holds
// the output side for a long time.
// ----------------------------------------------------------------------------

module tb_deadline_weighted_task_picker;
    import dwtp_pkg::*;

    localparam int unsigned TABLE_DEPTH    = 64;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          SETTLE_CYCLES  = 2 * TABLE_DEPTH + 16;
    localparam int          WATCHDOG_LIMIT = 8000;
    localparam int          LONG_HOLD      = 1500;

    typedef struct {
        bit        found;
        bit [5:0]  index;
        bit [15:0] duration;
        bit [23:0] elapsed;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        deadline_hours_wr_en = 1'b0;
    logic [15:0] deadline_hours_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // entry_index, arrival_hour, task_duration,
                                 // task_importance, zero pad
    logic [1:0]  s_tuser = OP_LOAD;  // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // chosen_index, chosen_duration, elapsed_after,
                                 // zero pad
    logic [0:0]  m_tuser;        // found

    // Bench copy of the block state
    entry_t    task_tbl [TABLE_DEPTH];
    bit [23:0] model_elapsed = '0;
    bit [15:0] model_deadline = '0;

    pick_t expected_picks [$];
    int    mismatches = 0;

    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    deadline_weighted_task_picker #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .deadline_hours_wr_en   (deadline_hours_wr_en),
        .deadline_hours_wr_data (deadline_hours_wr_data),
        .s_tvalid               (s_tvalid),
        .s_tready               (s_tready),
        .s_tdata                (s_tdata),
        .s_tuser                (s_tuser),
        .m_tvalid               (m_tvalid),
        .m_tready               (m_tready),
        .m_tdata                (m_tdata),
        .m_tuser                (m_tuser)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return int'($urandom_range(1, 3));
        else if (r < 95)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Scan the ready entries, take the best score (lowest slot on a tie),
    // retire it and advance the elapsed time.
    function automatic pick_t pick_next_task();
        pick_t  res;
        longint pen;
        longint score;
        longint best_score;
        int     best;
        bit     have;
        int unsigned sum;
        res = '{1'b0, 6'd0, 16'd0, 24'd0};
        have = 1'b0;
        best = 0;
        best_score = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!task_tbl[i].valid)
                continue;
            if ({task_tbl[i].arrival, 8'h00} > model_elapsed)
                continue;
            pen = (longint'(model_deadline) * 256 - longint'(task_tbl[i].duration)
                   - longint'(model_elapsed)) * 2;
            score = pen * longint'(task_tbl[i].importance);
            if (!have || score > best_score)
            begin
                have = 1'b1;
                best = i;
                best_score = score;
            end
        end
        if (have)
        begin
            sum = 32'(model_elapsed) + 32'(task_tbl[best].duration);
            if (sum > 32'hFF_FFFF)
                sum = 32'hFF_FFFF;
            task_tbl[best].valid = 1'b0;
            model_elapsed = sum[23:0];
            res.found = 1'b1;
            res.index = best[5:0];
            res.duration = task_tbl[best].duration;
        end
        res.elapsed = model_elapsed;
        return res;
    endfunction

    function automatic void note_mismatch(string field, longint exp_v, longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, field,
                     exp_v, act_v);
    endfunction

    // One beat on the input stream; the model follows once it is accepted
    task automatic send_beat(input logic [1:0] op, input logic [5:0] slot,
                             input logic [7:0] arrival, input logic [15:0] duration,
                             input logic [15:0] importance);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 35) ? idle_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, importance, duration, arrival, slot};
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_LOAD:
                task_tbl[slot] = '{1'b1, arrival, duration, importance};
            OP_SELECT:
                expected_picks.push_back(pick_next_task());
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    task_tbl[i].valid = 1'b0;
                model_elapsed = '0;
            end
            default:
                ;
        endcase
    endtask

    task automatic send_select();
        send_beat(OP_SELECT, 6'($urandom()), 8'($urandom()), 16'($urandom()),
                  16'($urandom()));
    endtask

    task automatic send_clear();
        send_beat(OP_CLEAR, 6'($urandom()), 8'($urandom()), 16'($urandom()),
                  16'($urandom()));
    endtask

    task automatic send_unused();
        send_beat(OP_UNUSED, 6'($urandom()), 8'($urandom()), 16'($urandom()),
                  16'($urandom()));
    endtask

    // Arrival mostly at most four hours past the current hour so that entries get ready
    task automatic load_random_task();
        int hour;
        logic [7:0]  arrival;
        logic [15:0] duration;
        hour = int'(model_elapsed[23:8]);
        if ($urandom_range(0, 99) < 75)
            arrival = (hour + 4 > 255) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, hour + 4));
        else
            arrival = 8'($urandom());
        duration = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 16'h0800))
                                                : 16'($urandom());
        send_beat(OP_LOAD, 6'($urandom()), arrival, duration, 16'($urandom()));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the block idle: a clear may still be running
    task automatic set_deadline(input logic [15:0] hours);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        deadline_hours_wr_en <= 1'b1;
        deadline_hours_wr_data <= hours;
        @(posedge clk);
        deadline_hours_wr_en <= 1'b0;
        model_deadline = hours;
    endtask

    task automatic test_directed_cases();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_deadline(16'd100);
        send_select();                                         // empty table
        send_beat(OP_LOAD, 6'd0, 8'd0, 16'h0000, 16'h7FFF);
        send_beat(OP_LOAD, 6'd63, 8'd255, 16'hFFFF, 16'h8000);
        send_beat(OP_LOAD, 6'd1, 8'd0, 16'hFFFF, 16'h8000);
        send_beat(OP_LOAD, 6'd2, 8'd0, 16'h0100, 16'h0100);   // tie pair
        send_beat(OP_LOAD, 6'd3, 8'd0, 16'h0100, 16'h0100);
        send_unused();
        repeat (6) send_select();                              // the last one finds nothing
        send_beat(OP_LOAD, 6'd5, 8'd0, 16'h0040, 16'h0000);
        send_clear();
        send_select();                                         // cleared: not found
        send_beat(OP_LOAD, 6'd7, 8'd1, 16'h0200, 16'h0300);   // not ready at zero
        send_select();
        send_beat(OP_LOAD, 6'd8, 8'd0, 16'h0100, 16'hFF00);
        send_select();
        send_select();
        send_beat(OP_LOAD, 6'd9, 8'd0, 16'h0000, 16'h0000);
        send_select();
    endtask

    task automatic test_random_schedule(input int phases);
        int n;
        int picks;
        int r;
        for (int p = 0; p < phases; p++)
        begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (p == 0)
                set_deadline(16'd0);
            else if (p == 1)
                set_deadline(16'hFFFF);
            else if ($urandom_range(0, 1) == 0)
                set_deadline(16'($urandom_range(0, 400)));
            else
                set_deadline(16'($urandom()));
            send_clear();
            n = int'($urandom_range(2, 40));
            repeat (n) load_random_task();
            picks = n + int'($urandom_range(1, 4));
            while (picks > 0)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 12)
                    load_random_task();
                else if (r < 15)
                    send_unused();
                else if (r < 16)
                    send_clear();
                else
                begin
                    send_select();
                    picks--;
                end
            end
        end
    endtask

    // Long durations push the elapsed time into saturation
    task automatic test_elapsed_saturation();
        int hour;
        logic [15:0] duration;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_deadline(16'($urandom()));
        send_clear();
        repeat (300)
        begin
            hour = int'(model_elapsed[23:8]);
            duration = ($urandom_range(0, 99) < 70) ? 16'hFFFF
                                                     : 16'($urandom_range(16'hE000, 16'hFFFF));
            send_beat(OP_LOAD, 6'($urandom()),
                      8'($urandom_range(0, (hour > 255) ? 255 : hour)),
                      duration, 16'($urandom()));
            send_select();
        end
    endtask

    // Output held off while selects keep coming, so the input side stalls
    task automatic test_output_stall();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_deadline(16'($urandom_range(0, 300)));
        send_clear();
        repeat (8) send_beat(OP_LOAD, 6'($urandom()), 8'd0,
                             16'($urandom_range(0, 16'h0400)), 16'($urandom()));
        hold_request = LONG_HOLD;
        repeat (8) send_select();
        wait_drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (6) load_random_task();
        repeat (6) send_select();
    endtask

    // Output side: random stalls, and checking of each result beat
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result beat with nothing expected: tuser %0h tdata %0h",
                             $realtime, m_tuser, m_tdata);
            end
            else
            begin
                pick_t exp_pick;
                exp_pick = expected_picks.pop_front();
                if (m_tuser[0] !== exp_pick.found)
                    note_mismatch("found", longint'(exp_pick.found), longint'(m_tuser[0]));
                if (m_tdata[5:0] !== exp_pick.index)
                    note_mismatch("chosen_index", longint'(exp_pick.index),
                                  longint'(m_tdata[5:0]));
                if (m_tdata[21:6] !== exp_pick.duration)
                    note_mismatch("chosen_duration", longint'(exp_pick.duration),
                                  longint'(m_tdata[21:6]));
                if (m_tdata[45:22] !== exp_pick.elapsed)
                    note_mismatch("elapsed_after", longint'(exp_pick.elapsed),
                                  longint'(m_tdata[45:22]));
            end
        end
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!rx_gaps)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 60)
            m_tready <= 1'b1;
        else
        begin
            stall_left = idle_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            task_tbl[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_stall();
        test_random_schedule(12);
        test_elapsed_saturation();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
design/dwtp_pkg.sv
design/dwtp_table.sv
design/dwtp_scorer.sv
design/deadline_weighted_task_picker.sv
bench/tb_deadline_weighted_task_picker.sv
